@@ sv/xsprng_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xsprng_pkg
// Shared types and constants of the eight-lane xoshiro / sfc generator:
// beat payloads, per-lane control, function and algorithm codes, rotations.
// ----------------------------------------------------------------------------
package xsprng_pkg;

    // Function codes of an input beat
    localparam logic FUNC_DRAW = 1'b0;
    localparam logic FUNC_LOAD = 1'b1;

    // Algorithm codes (code 3 runs the sfc64 step)
    localparam logic [1:0] ALGO_PLUSPLUS = 2'd0;
    localparam logic [1:0] ALGO_STARSTAR = 2'd1;
    localparam logic [1:0] ALGO_SFC      = 2'd2;

    // State word selectors of a load
    localparam logic [1:0] WORD_ZERO  = 2'd0;
    localparam logic [1:0] WORD_ONE   = 2'd1;
    localparam logic [1:0] WORD_TWO   = 2'd2;
    localparam logic [1:0] WORD_THREE = 2'd3;

    // Rotation and shift amounts
    localparam int ROT_PP     = 23;
    localparam int ROT_SS     = 7;
    localparam int ROT_STATE  = 45;
    localparam int SHL_STATE  = 17;
    localparam int SHR_SFC    = 11;
    localparam int ROT_SFC    = 24;

    // Input beat payload
    typedef struct packed {
        logic        func;
        logic [1:0]  word_select;
        logic [2:0]  lane_index;
        logic [63:0] load_value;
    } t_in_item;

    // Result beat payload
    typedef struct packed {
        logic [63:0] random_value;
        logic [2:0]  lane;
        logic        last;
    } t_out_item;

    // Control handed to one lane each cycle
    typedef struct packed {
        logic        draw;
        logic        load;
        logic [1:0]  algorithm;
        logic [1:0]  word_select;
        logic [63:0] load_value;
    } t_lane_ctrl;

    // Rotate a 64-bit word left by a constant amount (1..63)
    function automatic logic [63:0] rotl64(input logic [63:0] x, input int k);
        return (x << k) | (x >> (64 - k));
    endfunction

endpackage

@@ sv/xsprng_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xsprng_lane
// One generator lane: four 64-bit state words, the result of the current
// state for the selected algorithm, the state step on a draw and seeding.
// ----------------------------------------------------------------------------
module xsprng_lane (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  xsprng_pkg::t_lane_ctrl  i_ctrl,
    output logic [63:0]             o_result
);

    logic [63:0] r_w0, r_w1, r_w2, r_w3;
    logic [63:0] n_w0, n_w1, n_w2, n_w3;

    logic [63:0] pp_sum;
    logic [63:0] ss_mul5;
    logic [63:0] ss_rot;
    logic [63:0] res_pp;
    logic [63:0] res_ss;
    logic [63:0] res_sfc;
    logic [63:0] xs_w0, xs_w1, xs_w2, xs_w3;

    // Form the result of each algorithm from the current state
    always_comb begin
        pp_sum  = r_w0 + r_w3;
        res_pp  = xsprng_pkg::rotl64(pp_sum, xsprng_pkg::ROT_PP) + r_w0;
        ss_mul5 = r_w1 + (r_w1 << 2);
        ss_rot  = xsprng_pkg::rotl64(ss_mul5, xsprng_pkg::ROT_SS);
        res_ss  = ss_rot + (ss_rot << 3);
        res_sfc = r_w0 + r_w1 + r_w3;
    end

    // Pick the result for the active algorithm
    always_comb begin
        case (i_ctrl.algorithm)
            xsprng_pkg::ALGO_PLUSPLUS: o_result = res_pp;
            xsprng_pkg::ALGO_STARSTAR: o_result = res_ss;
            default:                   o_result = res_sfc;
        endcase
    end

    // Shared xoshiro256 state update
    always_comb begin
        xs_w2 = r_w2 ^ r_w0;
        xs_w3 = r_w3 ^ r_w1;
        xs_w1 = r_w1 ^ xs_w2;
        xs_w0 = r_w0 ^ xs_w3;
        xs_w2 = xs_w2 ^ (r_w1 << xsprng_pkg::SHL_STATE);
        xs_w3 = xsprng_pkg::rotl64(xs_w3, xsprng_pkg::ROT_STATE);
    end

    // Advance on a draw, write one word on a load, else hold
    always_comb begin
        n_w0 = r_w0;
        n_w1 = r_w1;
        n_w2 = r_w2;
        n_w3 = r_w3;
        if (i_ctrl.draw) begin
            if (i_ctrl.algorithm[1]) begin
                n_w0 = r_w1 ^ (r_w1 >> xsprng_pkg::SHR_SFC);
                n_w1 = r_w2 + (r_w2 << 3);
                n_w2 = xsprng_pkg::rotl64(r_w2, xsprng_pkg::ROT_SFC) + res_sfc;
                n_w3 = r_w3 + 64'd1;
            end else begin
                n_w0 = xs_w0;
                n_w1 = xs_w1;
                n_w2 = xs_w2;
                n_w3 = xs_w3;
            end
        end else if (i_ctrl.load) begin
            case (i_ctrl.word_select)
                xsprng_pkg::WORD_ZERO:  n_w0 = i_ctrl.load_value;
                xsprng_pkg::WORD_ONE:   n_w1 = i_ctrl.load_value;
                xsprng_pkg::WORD_TWO:   n_w2 = i_ctrl.load_value;
                xsprng_pkg::WORD_THREE: n_w3 = i_ctrl.load_value;
                default:                n_w3 = i_ctrl.load_value;
            endcase
        end
    end

    // State words start from zero until seeded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w0 <= '0;
            r_w1 <= '0;
            r_w2 <= '0;
            r_w3 <= '0;
        end else begin
            r_w0 <= n_w0;
            r_w1 <= n_w1;
            r_w2 <= n_w2;
            r_w3 <= n_w3;
        end
    end

endmodule

@@ sv/xsprng_outbuf.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xsprng_outbuf
// Result buffer: captures one value per lane of a draw and shifts them out
// one beat per cycle unless stalled, in lane order, flagging the last lane.
// ----------------------------------------------------------------------------
module xsprng_outbuf #(
    parameter int LANE_COUNT = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_fill,
    input  logic [63:0]            i_values [LANE_COUNT],
    output logic                   o_free,
    output logic                   o_valid,
    input  logic                   i_stall,
    output xsprng_pkg::t_out_item  o_data
);

    localparam int CNT_W = (LANE_COUNT > 1) ? $clog2(LANE_COUNT) : 1;
    localparam logic [CNT_W-1:0] LAST_LANE = CNT_W'(LANE_COUNT - 1);

    logic             r_valid;
    logic [CNT_W-1:0] r_cnt;
    logic [63:0]      r_vals [LANE_COUNT];
    logic             pop;
    logic             at_last;

    assign at_last = (r_cnt == LAST_LANE);
    assign pop     = r_valid && !i_stall;
    assign o_free  = !r_valid || (pop && at_last);

    // Present the head entry
    assign o_valid             = r_valid;
    assign o_data.random_value = r_vals[0];
    assign o_data.lane         = 3'(r_cnt);
    assign o_data.last         = at_last;

    // Track occupancy and lane count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else if (i_fill) begin
            r_valid <= 1'b1;
            r_cnt   <= '0;
        end else if (pop) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (at_last) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Load a full draw, or shift toward the head on each beat
    always_ff @(posedge i_clk) begin
        if (i_fill) begin
            r_vals <= i_values;
        end else if (pop) begin
            for (int k = 0; k < LANE_COUNT - 1; k++) begin
                r_vals[k] <= r_vals[k + 1];
            end
        end
    end

endmodule

@@ sv/eight_lane_xoshiro_sfc_prng.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eight_lane_xoshiro_sfc_prng
// Multi-lane xoshiro256++ / xoshiro256** / sfc64 generator with per-lane
// seeding. Input beats are registered; a draw steps all lanes at once, a load one.
// ----------------------------------------------------------------------------
// Results: the first result beat of a draw is presented from the result buffer,
//   which is filled as the draw leaves the input register.
// Draws: the result port gives one beat per cycle unless stalled; the next draw
//   is computed while the last beat drains.
// Loads proceed while results drain.
// Reset: all state words cleared to zero, algorithm set to xoshiro256++.
module eight_lane_xoshiro_sfc_prng #(
    parameter int LANE_COUNT = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration
    input  logic                   i_cfg_we,
    input  logic [1:0]             i_cfg_wdata,
    // input beats
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  xsprng_pkg::t_in_item   i_in_data,
    // result beats
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output xsprng_pkg::t_out_item  o_out_data
);

    logic [1:0]           r_algorithm;
    logic                 r_in_valid;
    xsprng_pkg::t_in_item r_in;

    logic                 in_accept;
    logic                 in_adv;
    logic                 buf_free;
    logic                 do_draw;
    logic                 do_load;
    logic [63:0]          lane_results [LANE_COUNT];

    // Hold the algorithm register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_algorithm <= xsprng_pkg::ALGO_PLUSPLUS;
        end else if (i_cfg_we) begin
            r_algorithm <= i_cfg_wdata;
        end
    end

    // A load always advances; a draw advances once the buffer frees up
    assign in_adv     = r_in_valid && ((r_in.func == xsprng_pkg::FUNC_LOAD) || buf_free);
    assign o_in_stall = r_in_valid && !in_adv;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign do_draw    = in_adv && (r_in.func == xsprng_pkg::FUNC_DRAW);
    assign do_load    = in_adv && (r_in.func == xsprng_pkg::FUNC_LOAD);

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (in_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in_data;
        end
    end

    // Generator lanes
    for (genvar i = 0; i < LANE_COUNT; i++) begin : g_lane
        xsprng_pkg::t_lane_ctrl lane_ctrl;

        always_comb begin
            lane_ctrl.draw        = do_draw;
            lane_ctrl.load        = do_load && (32'(r_in.lane_index) == i);
            lane_ctrl.algorithm   = r_algorithm;
            lane_ctrl.word_select = r_in.word_select;
            lane_ctrl.load_value  = r_in.load_value;
        end

        xsprng_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctrl   (lane_ctrl),
            .o_result (lane_results[i])
        );
    end

    // Result buffer
    xsprng_outbuf #(
        .LANE_COUNT (LANE_COUNT)
    ) u_outbuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fill   (do_draw),
        .i_values (lane_results),
        .o_free   (buf_free),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_data   (o_out_data)
    );

    // Checks
    a_fill_starts_lane0 : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_draw |=> o_out_valid && (o_out_data.lane == 3'd0))
        else $error("draw did not start at lane zero");

    a_lane_step : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_out_data.last && !do_draw)
        |=> o_out_valid && (o_out_data.lane == 3'($past(o_out_data.lane) + 3'd1)))
        else $error("result lanes out of order");

    a_last_lane : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.last) |-> (o_out_data.lane == 3'(LANE_COUNT - 1)))
        else $error("last flag on wrong lane");

    a_load_silent : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid && do_load) |=> !o_out_valid)
        else $error("load produced a result");

endmodule
